/* src/e2q_pkg.sv */
// ----------------------------------------------------------------------------
// e2q_pkg
// shared widths, constants and helper functions for the euler to quaternion
// converter
// ----------------------------------------------------------------------------
package e2q_pkg;

  localparam int ANGLE_W          = 12;
  localparam int ANGLE_Y_W        = 11;
  localparam int ANG_XZ_MAX       = 1800;
  localparam int ANG_Y_MAX        = 900;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;
  localparam int CW               = 34;
  localparam int HALF_TENTH_Q30   = 937017;
  localparam int GAIN_Q30         = 652032874;
  localparam int TRIG_RND_SH      = 14;

  localparam int TRIG_W           = 18;
  localparam int PAIR_W           = 2 * TRIG_W;
  localparam int PROD_W           = 3 * TRIG_W;
  localparam int SUM_W            = PROD_W + 1;
  localparam int Q_SH             = 34;
  localparam int Q_W              = 16;
  localparam int Q14_MAX          = 16384;

  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef logic signed [Q_W-1:0]    quat_t;

  function automatic logic [31:0] atan_q30(input int idx);
    logic [31:0] v;
    case (idx)
      0:       v = 32'h3243F6A8;
      1:       v = 32'h1DAC6705;
      2:       v = 32'h0FADBAFC;
      3:       v = 32'h07F56EA6;
      4:       v = 32'h03FEAB76;
      5:       v = 32'h01FFD55B;
      6:       v = 32'h00FFFAAA;
      7:       v = 32'h007FFF55;
      8:       v = 32'h003FFFEA;
      9:       v = 32'h001FFFFD;
      10:      v = 32'h000FFFFF;
      11:      v = 32'h0007FFFF;
      12:      v = 32'h0003FFFF;
      13:      v = 32'h0001FFFF;
      14:      v = 32'h0000FFFF;
      15:      v = 32'h00007FFF;
      16:      v = 32'h00003FFF;
      17:      v = 32'h00001FFF;
      18:      v = 32'h00000FFF;
      19:      v = 32'h000007FF;
      20:      v = 32'h000003FF;
      21:      v = 32'h000001FF;
      22:      v = 32'h000000FF;
      23:      v = 32'h0000007F;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // round Q48 to Q1.14 and saturate to unit range
  function automatic quat_t to_q14(input logic signed [SUM_W-1:0] p);
    logic signed [SUM_W-1:0]    t;
    logic signed [SUM_W-Q_SH-1:0] r;
    logic signed [Q_W-1:0]      qpos;
    logic signed [Q_W-1:0]      qneg;
    qpos = Q_W'(Q14_MAX);
    qneg = -qpos;
    t = p + (SUM_W'(1) <<< (Q_SH - 1));
    r = t[SUM_W-1:Q_SH];
    if (r > qpos) begin
      return qpos;
    end else if (r < qneg) begin
      return qneg;
    end
    return r[Q_W-1:0];
  endfunction

endpackage

/* src/e2q_lane.sv */
// ----------------------------------------------------------------------------
// e2q_lane
// one angle lane: half angle to radians, pipelined rotation-mode cordic,
// cosine and sine rounded to Q16
// ----------------------------------------------------------------------------
module e2q_lane #(
  parameter int STEPS = e2q_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [e2q_pkg::ANGLE_W-1:0]  angle,
  output e2q_pkg::trig_t                      cos_o,
  output e2q_pkg::trig_t                      sin_o
);
  import e2q_pkg::*;

  localparam logic signed [CW-1:0] HALF_K = CW'(HALF_TENTH_Q30);
  localparam logic signed [CW-1:0] GAIN_K = CW'(GAIN_Q30);
  localparam logic signed [CW-1:0] RND_K  = CW'(1) <<< (TRIG_RND_SH - 1);

  logic signed [CW-1:0] x_r [0:STEPS];
  logic signed [CW-1:0] y_r [0:STEPS];
  logic signed [CW-1:0] z_r [0:STEPS];
  logic signed [CW-1:0] z0_nxt;
  logic signed [CW-1:0] cs_sum;
  logic signed [CW-1:0] sn_sum;
  trig_t                cos_r;
  trig_t                sin_r;

  assign z0_nxt = CW'(angle) * HALF_K;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= GAIN_K;
      y_r[0] <= '0;
      z_r[0] <= z0_nxt;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic signed [CW-1:0] ATAN_K = CW'(signed'({1'b0, atan_q30(i)}));
    logic signed [CW-1:0] x_nxt;
    logic signed [CW-1:0] y_nxt;
    logic signed [CW-1:0] z_nxt;

    always_comb begin
      if (!z_r[i][CW-1]) begin
        x_nxt = x_r[i] - (y_r[i] >>> i);
        y_nxt = y_r[i] + (x_r[i] >>> i);
        z_nxt = z_r[i] - ATAN_K;
      end else begin
        x_nxt = x_r[i] + (y_r[i] >>> i);
        y_nxt = y_r[i] - (x_r[i] >>> i);
        z_nxt = z_r[i] + ATAN_K;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1] <= x_nxt;
        y_r[i+1] <= y_nxt;
        z_r[i+1] <= z_nxt;
      end
    end
  end

  assign cs_sum = x_r[STEPS] + RND_K;
  assign sn_sum = y_r[STEPS] + RND_K;

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= cs_sum[TRIG_RND_SH +: TRIG_W];
      sin_r <= sn_sum[TRIG_RND_SH +: TRIG_W];
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

/* src/e2q_merge.sv */
// ----------------------------------------------------------------------------
// e2q_merge
// combines the three lanes: pair products, three-factor products, then sum,
// rounding and saturation into the output register
// ----------------------------------------------------------------------------
module e2q_merge (
  input  logic            clk,
  input  logic            en,
  input  e2q_pkg::trig_t  cx,
  input  e2q_pkg::trig_t  sx,
  input  e2q_pkg::trig_t  cy,
  input  e2q_pkg::trig_t  sy,
  input  e2q_pkg::trig_t  cz,
  input  e2q_pkg::trig_t  sz,
  output e2q_pkg::quat_t  quat_w,
  output e2q_pkg::quat_t  quat_x,
  output e2q_pkg::quat_t  quat_y,
  output e2q_pkg::quat_t  quat_z
);
  import e2q_pkg::*;

  // pair stage
  logic signed [PAIR_W-1:0] cycz_r, sysz_r, sycz_r, cysz_r;
  trig_t                    cx_r, sx_r;

  // triple stage
  logic signed [PROD_W-1:0] pw_a_r, pw_b_r, px_a_r, px_b_r;
  logic signed [PROD_W-1:0] py_a_r, py_b_r, pz_a_r, pz_b_r;

  quat_t w_r, x_r, y_r, z_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cycz_r <= cy * cz;
      sysz_r <= sy * sz;
      sycz_r <= sy * cz;
      cysz_r <= cy * sz;
      cx_r   <= cx;
      sx_r   <= sx;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pw_a_r <= PROD_W'(cx_r * cycz_r);
      pw_b_r <= PROD_W'(sx_r * sysz_r);
      px_a_r <= PROD_W'(sx_r * cycz_r);
      px_b_r <= PROD_W'(cx_r * sysz_r);
      py_a_r <= PROD_W'(cx_r * sycz_r);
      py_b_r <= PROD_W'(sx_r * cysz_r);
      pz_a_r <= PROD_W'(cx_r * cysz_r);
      pz_b_r <= PROD_W'(sx_r * sycz_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r <= to_q14(SUM_W'(pw_a_r) - SUM_W'(pw_b_r));
      x_r <= to_q14(SUM_W'(px_a_r) + SUM_W'(px_b_r));
      y_r <= to_q14(SUM_W'(py_a_r) - SUM_W'(py_b_r));
      z_r <= to_q14(SUM_W'(pz_a_r) + SUM_W'(pz_b_r));
    end
  end

  assign quat_w = w_r;
  assign quat_x = x_r;
  assign quat_y = y_r;
  assign quat_z = z_r;

endmodule

/* src/euler_xyz_to_quaternion.sv */
// ----------------------------------------------------------------------------
// euler_xyz_to_quaternion
// throughput: one beat per cycle, set by the fully pipelined cordic lanes
// a stalled valid output holds the whole pipeline in place
// reset (rst_n, synchronous) clears all valid bits, the pipeline comes up empty
// ----------------------------------------------------------------------------
module euler_xyz_to_quaternion #(
  parameter int CORDIC_STEPS = e2q_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [e2q_pkg::ANGLE_W-1:0]    in_angle_x,
  input  logic signed [e2q_pkg::ANGLE_Y_W-1:0]  in_angle_y,
  input  logic signed [e2q_pkg::ANGLE_W-1:0]    in_angle_z,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output e2q_pkg::quat_t                        out_quat_w,
  output e2q_pkg::quat_t                        out_quat_x,
  output e2q_pkg::quat_t                        out_quat_y,
  output e2q_pkg::quat_t                        out_quat_z
);
  import e2q_pkg::*;

  localparam int LAT = CORDIC_STEPS + 5;

  localparam logic signed [ANGLE_W-1:0]   XZ_HI = ANGLE_W'(ANG_XZ_MAX);
  localparam logic signed [ANGLE_W-1:0]   XZ_LO = -XZ_HI;
  localparam logic signed [ANGLE_Y_W-1:0] Y_HI  = ANGLE_Y_W'(ANG_Y_MAX);
  localparam logic signed [ANGLE_Y_W-1:0] Y_LO  = -Y_HI;

  logic [LAT-1:0]              vld_r;
  logic [LAT-1:0]              vld_nxt;
  logic                        en;
  logic signed [ANGLE_W-1:0]   ax_sat, ay_sat, az_sat;
  logic signed [ANGLE_Y_W-1:0] ay_lim;
  trig_t                       cx, sx, cy, sy, cz, sz;

  assign en       = !vld_r[LAT-1] || !out_stall;
  assign in_stall = !en;
  assign vld_nxt  = {vld_r[LAT-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // saturate angles to their ranges
  always_comb begin
    if (in_angle_x > XZ_HI) begin
      ax_sat = XZ_HI;
    end else if (in_angle_x < XZ_LO) begin
      ax_sat = XZ_LO;
    end else begin
      ax_sat = in_angle_x;
    end
    if (in_angle_z > XZ_HI) begin
      az_sat = XZ_HI;
    end else if (in_angle_z < XZ_LO) begin
      az_sat = XZ_LO;
    end else begin
      az_sat = in_angle_z;
    end
    if (in_angle_y > Y_HI) begin
      ay_lim = Y_HI;
    end else if (in_angle_y < Y_LO) begin
      ay_lim = Y_LO;
    end else begin
      ay_lim = in_angle_y;
    end
    ay_sat = ANGLE_W'(ay_lim);
  end

  e2q_lane #(.STEPS(CORDIC_STEPS)) u_lane_x (
    .clk   (clk),
    .en    (en),
    .angle (ax_sat),
    .cos_o (cx),
    .sin_o (sx)
  );

  e2q_lane #(.STEPS(CORDIC_STEPS)) u_lane_y (
    .clk   (clk),
    .en    (en),
    .angle (ay_sat),
    .cos_o (cy),
    .sin_o (sy)
  );

  e2q_lane #(.STEPS(CORDIC_STEPS)) u_lane_z (
    .clk   (clk),
    .en    (en),
    .angle (az_sat),
    .cos_o (cz),
    .sin_o (sz)
  );

  e2q_merge u_merge (
    .clk    (clk),
    .en     (en),
    .cx     (cx),
    .sx     (sx),
    .cy     (cy),
    .sy     (sy),
    .cz     (cz),
    .sz     (sz),
    .quat_w (out_quat_w),
    .quat_x (out_quat_x),
    .quat_y (out_quat_y),
    .quat_z (out_quat_z)
  );

  assign out_valid = vld_r[LAT-1];

endmodule
